### rtl/core/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg: shared codes for the linear-probe hash table
// Request kinds, result status codes and fixed field widths.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int KEY_W = 64;
    localparam int VAL_W = 32;
    localparam int OCC_W = 7;

    // request kinds
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    // result status
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

endpackage

### rtl/core/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table: open-addressing hash table with linear probing
// Steps: hash each of the L kept key bytes (S_HASH, S_FOLD), probe P slots
// (S_READ, S_CHECK), then S_RESP; refused inserts, empty-table lookups and
// removes and unknown requests go from S_IDLE straight to S_RESP. One
// request in flight; the next request is taken once back in idle.
// Reset: a clearing pass (S_CLEAR) sweeps every slot of the valid-bit RAM.
// ----------------------------------------------------------------------------
module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int SLOTS     = 64,
    parameter int KEY_BYTES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_req_type,
    input  logic [KEY_W-1:0] i_req_key,
    input  logic [VAL_W-1:0] i_req_value,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [1:0]       o_status,
    output logic [VAL_W-1:0] o_out_value,
    output logic [OCC_W-1:0] o_occupancy
);

    localparam int IW = $clog2(SLOTS);        // slot index width
    localparam int CW = $clog2(SLOTS + 1);    // entry count width
    localparam int XW = IW + 8;               // width of h*128 + byte
    localparam logic [XW-1:0] SLOTS_X = XW'(SLOTS);
    localparam logic [XW-1:0] RECIP   = XW'((1 << XW) / SLOTS);
    localparam logic [IW-1:0] LAST    = IW'(SLOTS - 1);

    // One-hot sequencer states
    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,   // sweep valid bits after reset
        S_IDLE  = 7'b0000010,   // wait for a request
        S_HASH  = 7'b0000100,   // fold in one key byte, quotient estimate
        S_FOLD  = 7'b0001000,   // remainder of that byte's fold
        S_READ  = 7'b0010000,   // slot address presented to the RAMs
        S_CHECK = 7'b0100000,   // slot data back, decide
        S_RESP  = 7'b1000000    // hand result to the output register
    } t_state;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state           r_state, n_state;
    logic [IW-1:0]    r_idx, n_idx;       // hash accumulator, then probe slot
    logic [CW-1:0]    r_count, n_count;
    logic [IW-1:0]    r_probe, n_probe;   // slots examined so far
    logic [1:0]       r_type, n_type;
    logic [KEY_W-1:0] r_key, n_key;       // normalized key
    logic [VAL_W-1:0] r_value, n_value;
    logic [3:0]       r_len, n_len;       // key bytes to hash
    logic [2:0]       r_byte, n_byte;
    logic [XW-1:0]    r_quot, n_quot;     // quotient estimate of the fold
    logic [1:0]       r_res_status, n_res_status;
    logic [VAL_W-1:0] r_res_value, n_res_value;
    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_out_status, n_out_status;
    logic [VAL_W-1:0] r_out_value, n_out_value;
    logic [OCC_W-1:0] r_out_occ, n_out_occ;

    // ------------------------------------------------------------------
    // Slot storage: keys, values and valid bits, all addressed by r_idx.
    // Only the valid bits are cleared; keys and values are read only
    // behind a set valid bit.
    // ------------------------------------------------------------------
    logic             key_we, val_we, used_we;
    logic [0:0]       used_wdata;
    logic [0:0]       used_q;
    logic [KEY_W-1:0] key_q;
    logic [VAL_W-1:0] val_q;

    lpht_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
        .i_clk     (i_clk),
        .i_we      (key_we),
        .i_wr_addr (r_idx),
        .i_wr_data (r_key),
        .i_rd_addr (r_idx),
        .o_rd_data (key_q)
    );

    lpht_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_val_ram (
        .i_clk     (i_clk),
        .i_we      (val_we),
        .i_wr_addr (r_idx),
        .i_wr_data (r_value),
        .i_rd_addr (r_idx),
        .o_rd_data (val_q)
    );

    lpht_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_used_ram (
        .i_clk     (i_clk),
        .i_we      (used_we),
        .i_wr_addr (r_idx),
        .i_wr_data (used_wdata),
        .i_rd_addr (r_idx),
        .o_rd_data (used_q)
    );

    // ------------------------------------------------------------------
    // Key normalization: keep bytes up to the first zero byte and within
    // KEY_BYTES; everything after is cleared. key_len counts kept bytes.
    // ------------------------------------------------------------------
    logic [KEY_W-1:0] norm_key;
    logic [3:0]       key_len;
    logic             alive;

    always_comb begin
        alive    = 1'b1;
        norm_key = '0;
        key_len  = '0;
        for (int i = 0; i < 8; i++) begin
            if (i >= KEY_BYTES || i_req_key[8*i +: 8] == 8'd0) begin
                alive = 1'b0;
            end
            if (alive) begin
                norm_key[8*i +: 8] = i_req_key[8*i +: 8];
                key_len            = 4'(i + 1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared hash unit: h <- (h*128 + b) mod SLOTS, S_HASH then S_FOLD per byte.
    //   S_HASH: x = h*128 + b, q = (x * floor(2^XW / SLOTS)) >> XW,
    //           which is the true quotient or one below it
    //   S_FOLD: r = x - q*SLOTS is below 2*SLOTS, one compare-subtract
    // The single multiplier serves both steps.
    // ------------------------------------------------------------------
    logic [7:0]      hash_byte;
    logic [XW-1:0]   hash_x;
    logic [XW-1:0]   mul_a;
    logic [XW-1:0]   mul_b;
    logic [2*XW-1:0] mul_p;
    logic [XW-1:0]   hash_rem;
    logic [IW-1:0]   hash_next;

    always_comb begin
        hash_byte = r_key[{r_byte, 3'b000} +: 8];
        hash_x    = XW'({r_idx, 7'b0000000}) + XW'(hash_byte);
        mul_a     = (r_state == S_FOLD) ? r_quot  : hash_x;
        mul_b     = (r_state == S_FOLD) ? SLOTS_X : RECIP;
        mul_p     = (2*XW)'(mul_a) * (2*XW)'(mul_b);
        hash_rem  = hash_x - mul_p[XW-1:0];
        if (hash_rem >= SLOTS_X) begin
            hash_next = IW'(hash_rem - SLOTS_X);
        end else begin
            hash_next = IW'(hash_rem);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic key_hit;
    logic is_full;

    assign key_hit = (key_q == r_key);
    assign is_full = (r_count >= CW'(SLOTS));

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_count      = r_count;
        n_probe      = r_probe;
        n_type       = r_type;
        n_key        = r_key;
        n_value      = r_value;
        n_len        = r_len;
        n_byte       = r_byte;
        n_quot       = r_quot;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_occ    = r_out_occ;
        key_we       = 1'b0;
        val_we       = 1'b0;
        used_we      = 1'b0;
        used_wdata   = 1'b0;

        // output register drains on a transfer
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                used_we    = 1'b1;
                used_wdata = 1'b0;
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_IDLE: begin
                if (i_in_valid) begin
                    n_type      = i_req_type;
                    n_key       = norm_key;
                    n_value     = i_req_value;
                    n_len       = key_len;
                    n_idx       = '0;
                    n_probe     = '0;
                    n_byte      = '0;
                    n_res_value = '0;
                    if (i_req_type == REQ_INSERT && is_full) begin
                        // full table refuses even a key already present
                        n_res_status = STAT_FULL;
                        n_state      = S_RESP;
                    end else if (i_req_type == REQ_INSERT ||
                                 (i_req_type inside {REQ_LOOKUP, REQ_REMOVE} &&
                                  r_count != '0)) begin
                        n_res_status = STAT_NOT_FOUND;
                        // empty key hashes to slot zero
                        n_state = (key_len == 4'd0) ? S_READ : S_HASH;
                    end else begin
                        // empty table or unknown request kind
                        n_res_status = STAT_NOT_FOUND;
                        n_state      = S_RESP;
                    end
                end
            end

            S_HASH: begin
                n_quot  = mul_p[2*XW-1:XW];
                n_state = S_FOLD;
            end

            S_FOLD: begin
                n_idx = hash_next;
                if ({1'b0, r_byte} == 4'(r_len - 4'd1)) begin
                    n_state = S_READ;
                end else begin
                    n_byte  = r_byte + 1'b1;
                    n_state = S_HASH;
                end
            end

            S_READ: begin
                n_state = S_CHECK;
            end

            S_CHECK: begin
                if (r_type == REQ_INSERT) begin
                    // table not full, so the walk always ends at a free slot or at the key
                    if (!used_q[0] || key_hit) begin
                        key_we = 1'b1;
                        val_we = 1'b1;
                        if (!used_q[0]) begin
                            used_we    = 1'b1;
                            used_wdata = 1'b1;
                            n_count    = r_count + 1'b1;
                        end
                        n_res_status = STAT_OK;
                        n_state      = S_RESP;
                    end else begin
                        n_idx   = (r_idx == LAST) ? '0 : r_idx + 1'b1;
                        n_probe = r_probe + 1'b1;
                        n_state = S_READ;
                    end
                end else begin
                    // lookup or remove: walk the whole table past holes
                    if (used_q[0] && key_hit) begin
                        n_res_value  = val_q;
                        n_res_status = STAT_OK;
                        if (r_type == REQ_REMOVE) begin
                            used_we    = 1'b1;
                            used_wdata = 1'b0;
                            n_count    = r_count - 1'b1;
                        end
                        n_state = S_RESP;
                    end else if (r_probe == LAST) begin
                        n_res_status = STAT_NOT_FOUND;
                        n_state      = S_RESP;
                    end else begin
                        n_idx   = (r_idx == LAST) ? '0 : r_idx + 1'b1;
                        n_probe = r_probe + 1'b1;
                        n_state = S_READ;
                    end
                end
            end

            S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_value  = r_res_value;
                    n_out_occ    = OCC_W'(r_count);   // modulo 128
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_CLEAR;
                n_idx   = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_probe      <= n_probe;
        r_type       <= n_type;
        r_key        <= n_key;
        r_value      <= n_value;
        r_len        <= n_len;
        r_byte       <= n_byte;
        r_quot       <= n_quot;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_occ    <= n_out_occ;
    end

    // ports
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_out_value = r_out_value;
    assign o_occupancy = r_out_occ;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS))
        else $error("entry count above table size");

    a_count_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count)) |-> $past(r_state == S_CHECK))
        else $error("entry count moved outside slot decision");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST)
        else $error("slot index out of range");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == STAT_FULL |-> o_occupancy == OCC_W'(SLOTS))
        else $error("full status with table not full");

endmodule

### rtl/core/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
